/* rtl/core/satag_pkg.sv */
// satag_pkg: shared types and codes of the set-associative tag store
// command codes, line state codes and the result record
// no dependencies
package satag_pkg;

    localparam int CMD_W   = 2;
    localparam int STATE_W = 3;
    localparam int FIELD_W = 32;

    // command codes carried on the request channel
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_INSTALL = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_PROBE   = 2'd3
    } t_cmd;

    // invalid line state; any other code counts as a valid line
    localparam logic [STATE_W-1:0] ST_INVALID = 3'd0;

    // one result record
    typedef struct packed {
        logic               hit;
        logic [STATE_W-1:0] line_state;
        logic               need_evict;
        logic [FIELD_W-1:0] victim_address;
        logic [STATE_W-1:0] evict_state;
    } t_result;

endpackage

/* rtl/core/satag_if.sv */
// satag_req_if and satag_rsp_if: valid/ready channels of the tag store
// request carries command, address and write state; response carries the result
// depends on satag_pkg for field widths
interface satag_req_if;
    logic                          valid;
    logic                          ready;
    logic [satag_pkg::CMD_W-1:0]   command;
    logic [satag_pkg::FIELD_W-1:0] address;
    logic [satag_pkg::STATE_W-1:0] wr_state;

    modport source (output valid, command, address, wr_state, input ready);
    modport sink   (input valid, command, address, wr_state, output ready);
endinterface

interface satag_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [satag_pkg::STATE_W-1:0] line_state;
    logic                          need_evict;
    logic [satag_pkg::FIELD_W-1:0] victim_address;
    logic [satag_pkg::STATE_W-1:0] evict_state;

    modport source (output valid, hit, line_state, need_evict, victim_address,
                    evict_state, input ready);
    modport sink   (input valid, hit, line_state, need_evict, victim_address,
                    evict_state, output ready);
endinterface

/* rtl/core/satag_mem.sv */
// satag_mem: one-write one-read row memory with registered read data
// a read of the row being written in the same cycle returns the new data
// no dependencies
module satag_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, write-first on an address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/satag_eval.sv */
// satag_eval: per-set decision logic of the tag store
// hit, free and lru search, recency update, new row and result record
// depends on satag_pkg
module satag_eval #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 20,
    parameter int RANK_W = 2,
    parameter int SET_IW = 6,
    parameter int SET_W  = 6,
    parameter int OFF_W  = 6
) (
    input  logic                                                  i_valid,
    input  satag_pkg::t_cmd                                       i_cmd,
    input  logic [TAG_W-1:0]                                      i_tag,
    input  logic [SET_IW-1:0]                                     i_set,
    input  logic [satag_pkg::STATE_W-1:0]                         i_wr_state,
    input  logic [WAYS*(TAG_W + satag_pkg::STATE_W + RANK_W)-1:0] i_row,
    output logic                                                  o_wr_en,
    output logic [WAYS*(TAG_W + satag_pkg::STATE_W + RANK_W)-1:0] o_row,
    output satag_pkg::t_result                                    o_result
);
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0][RANK_W-1:0]             ranks, n_ranks;
    logic [WAYS-1:0][satag_pkg::STATE_W-1:0] states, n_states;
    logic [WAYS-1:0][TAG_W-1:0]              tags, n_tags;

    logic [WAYS-1:0]   hit_vec, free_vec, lru_vec;
    logic [WAY_IW-1:0] hit_way, open_way, lru_way, slot_way, touch_way;
    logic              any_hit, any_free, do_touch;
    logic [RANK_W-1:0] old_rank;
    logic [63:0]       victim_block;

    assign {ranks, states, tags} = i_row;

    // way search, lowest-numbered way wins
    always_comb begin
        hit_way  = '0;
        open_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w]  = (states[w] != satag_pkg::ST_INVALID) && (tags[w] == i_tag);
            free_vec[w] = (states[w] == satag_pkg::ST_INVALID);
            lru_vec[w]  = (ranks[w] == '0);
            if (hit_vec[w]) begin
                hit_way = WAY_IW'(w);
            end
            if (free_vec[w]) begin
                open_way = WAY_IW'(w);
            end
            if (lru_vec[w]) begin
                lru_way = WAY_IW'(w);
            end
        end
        any_hit  = |hit_vec;
        any_free = |free_vec;
        slot_way = any_hit ? hit_way : (any_free ? open_way : lru_way);
    end

    // victim block address rebuilt from tag and set
    assign victim_block = ((64'(tags[lru_way]) << SET_W) | 64'(i_set)) << OFF_W;

    // command decode, result record and new row
    always_comb begin
        n_tags    = tags;
        n_states  = states;
        o_wr_en   = 1'b0;
        do_touch  = 1'b0;
        touch_way = slot_way;
        o_result  = '0;
        case (i_cmd)
            satag_pkg::CMD_LOOKUP: begin
                if (any_hit) begin
                    o_result.hit        = 1'b1;
                    o_result.line_state = states[hit_way];
                    do_touch            = 1'b1;
                    o_wr_en             = i_valid;
                end else if (!any_free) begin
                    o_result.need_evict     = 1'b1;
                    o_result.victim_address = victim_block[satag_pkg::FIELD_W-1:0];
                    o_result.evict_state    = states[lru_way];
                end
            end
            satag_pkg::CMD_INSTALL: begin
                n_tags[slot_way]   = i_tag;
                n_states[slot_way] = i_wr_state;
                do_touch           = 1'b1;
                o_wr_en            = i_valid;
            end
            satag_pkg::CMD_UPDATE: begin
                if (any_hit) begin
                    n_states[hit_way] = i_wr_state;
                    o_wr_en           = i_valid;
                end
            end
            satag_pkg::CMD_PROBE: begin
                if (any_hit) begin
                    o_result.hit        = 1'b1;
                    o_result.line_state = states[hit_way];
                end
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    // recency update: ranks above the touched way move down by one
    always_comb begin
        old_rank = ranks[touch_way];
        n_ranks  = ranks;
        if (do_touch) begin
            for (int w = 0; w < WAYS; w++) begin
                if (ranks[w] > old_rank) begin
                    n_ranks[w] = ranks[w] - RANK_W'(1);
                end
            end
            n_ranks[touch_way] = RANK_W'(WAYS - 1);
        end
    end

    assign o_row = {n_ranks, n_states, n_tags};
endmodule

/* rtl/core/set_assoc_tag_store_lru.sv */
// Set-associative cache tag store with line states and true-LRU order.
// Request channel i_req: command, byte address and write state. Response
// channel o_rsp: hit, prior line state, eviction flag, victim block address
// and victim state. Every request gives exactly one response, in order.
// Commands: lookup reports hit and state (refreshing recency) or the LRU
// victim of a full set; install fills the resident, else lowest free, else
// LRU way; update rewrites the state of a resident line; probe only reads.
// Each request has its set row read from memory (registered), then one pass
// of decision logic writes the response register. Throughput: one request
// per cycle while responses are taken, including back to back requests to
// the same set, which see the row written by the previous one through the
// memory's write-first read path.
// Reset (synchronous, active low) starts a clearing pass over all SETS rows
// that marks every line invalid and sets ranks to way order; requests are
// held off (ready low) until it ends. Tags are written as zero by the same pass.
// A stalled response stays in the response register; the decision stage
// holds its request and ready falls until the response is taken.
// SETS and BLOCK_BYTES must be powers of two; the block itself does not enforce this.
// Depends on satag_pkg, satag_if, satag_mem and satag_eval.
module set_assoc_tag_store_lru #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    satag_req_if.sink      i_req,
    satag_rsp_if.source    o_rsp
);
    localparam int EFF_AW   = (ADDR_WIDTH < satag_pkg::FIELD_W) ? ADDR_WIDTH
                                                                : satag_pkg::FIELD_W;
    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int SET_W    = $clog2(SETS);
    localparam int SET_IW   = (SETS > 1) ? SET_W : 1;
    localparam int TAG_BITS = EFF_AW - OFF_W - SET_W;
    localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W    = WAYS * (TAG_W + satag_pkg::STATE_W + RANK_W);
    localparam logic [63:0] ADDR_MASK = (64'd1 << EFF_AW) - 64'd1;

    // clearing pass state
    logic              r_clearing;
    logic [SET_IW-1:0] r_clr_idx;

    // decision stage registers
    logic                          r_s1_valid;
    satag_pkg::t_cmd               r_s1_cmd;
    logic [TAG_W-1:0]              r_s1_tag;
    logic [SET_IW-1:0]             r_s1_set;
    logic [satag_pkg::STATE_W-1:0] r_s1_state;

    // response register
    logic               r_out_valid;
    satag_pkg::t_result r_out;

    logic               req_fire, s1_fire;
    logic [63:0]        req_addr, req_block;
    logic [SET_IW-1:0]  req_set;
    logic [TAG_W-1:0]   req_tag;
    logic [ROW_W-1:0]   rd_row, eval_row, clr_row, wr_row;
    logic               eval_wr_en, wr_en;
    logic [SET_IW-1:0]  wr_addr;
    satag_pkg::t_result eval_result;

    logic [WAYS-1:0][RANK_W-1:0]             clr_ranks;
    logic [WAYS-1:0][satag_pkg::STATE_W-1:0] clr_states;
    logic [WAYS-1:0][TAG_W-1:0]              clr_tags;

    // handshake
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_clearing && (!r_s1_valid || s1_fire);
    assign req_fire    = i_req.valid && i_req.ready;

    // address split into set and tag
    assign req_addr  = 64'(i_req.address) & ADDR_MASK;
    assign req_block = req_addr >> OFF_W;
    assign req_set   = SET_IW'(req_block & 64'(SETS - 1));
    assign req_tag   = TAG_W'(req_block >> SET_W);

    // clearing row: invalid lines, ranks in way order
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            clr_ranks[w]  = RANK_W'(w);
            clr_states[w] = satag_pkg::ST_INVALID;
            clr_tags[w]   = '0;
        end
        clr_row = {clr_ranks, clr_states, clr_tags};
    end

    // memory write source
    assign wr_en   = r_clearing || (s1_fire && eval_wr_en);
    assign wr_addr = r_clearing ? r_clr_idx : r_s1_set;
    assign wr_row  = r_clearing ? clr_row : eval_row;

    satag_mem #(
        .DEPTH (SETS),
        .WIDTH (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_row),
        .i_rd_en   (req_fire),
        .i_rd_addr (req_set),
        .o_rd_data (rd_row)
    );

    satag_eval #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W),
        .SET_IW (SET_IW),
        .SET_W  (SET_W),
        .OFF_W  (OFF_W)
    ) u_eval (
        .i_valid    (r_s1_valid),
        .i_cmd      (r_s1_cmd),
        .i_tag      (r_s1_tag),
        .i_set      (r_s1_set),
        .i_wr_state (r_s1_state),
        .i_row      (rd_row),
        .o_wr_en    (eval_wr_en),
        .o_row      (eval_row),
        .o_result   (eval_result)
    );

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == SET_IW'(SETS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + SET_IW'(1);
        end
    end

    // decision stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // decision stage payload
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_cmd   <= satag_pkg::t_cmd'(i_req.command);
            r_s1_tag   <= req_tag;
            r_s1_set   <= req_set;
            r_s1_state <= i_req.wr_state;
        end
    end

    // response register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response register payload
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= eval_result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.hit            = r_out.hit;
    assign o_rsp.line_state     = r_out.line_state;
    assign o_rsp.need_evict     = r_out.need_evict;
    assign o_rsp.victim_address = r_out.victim_address;
    assign o_rsp.evict_state    = r_out.evict_state;
endmodule

/* rtl/core/satag_checker.sv */
// satag_checker: port-level assertions for the tag store
// bound to set_assoc_tag_store_lru; depends on satag_pkg for field widths
module satag_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_hit,
    input logic [satag_pkg::STATE_W-1:0] i_line_state,
    input logic                          i_need_evict,
    input logic [satag_pkg::FIELD_W-1:0] i_victim_address,
    input logic [satag_pkg::STATE_W-1:0] i_evict_state
);
    // reset empties the response register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // a fresh response has an accepted request behind it, passed through the decision stage
    a_rsp_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("response without a matching request");

    // a hit never asks for an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_hit && i_need_evict))
        else $error("hit and eviction reported together");

    // victim fields are zero unless an eviction is reported
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_need_evict) |->
            (i_victim_address == '0) && (i_evict_state == '0))
        else $error("victim fields set without eviction");

    // a miss reports no line state
    a_miss_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_hit) |-> (i_line_state == '0))
        else $error("line state reported on a miss");
endmodule

bind set_assoc_tag_store_lru satag_checker u_satag_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_hit            (o_rsp.hit),
    .i_line_state     (o_rsp.line_state),
    .i_need_evict     (o_rsp.need_evict),
    .i_victim_address (o_rsp.victim_address),
    .i_evict_state    (o_rsp.evict_state)
);
